[rtl/sorted_zigzag_matrix_fill_assert.svh]
// ---------------------------------------------------------------------------
// sorted zigzag matrix fill assertion macros
// shared property wrappers for the block's checkers
// ---------------------------------------------------------------------------
`ifndef SORTED_ZIGZAG_MATRIX_FILL_ASSERT_SVH
`define SORTED_ZIGZAG_MATRIX_FILL_ASSERT_SVH

// clocked property, ignored while reset is asserted
`define SZZ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked property, also checked during reset
`define SZZ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/szz_pkg.sv]
// ---------------------------------------------------------------------------
// szz_pkg
// types and constants shared by the sorted zigzag matrix fill block
// ---------------------------------------------------------------------------
package szz_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

    // field widths
    localparam int DIM_W     = 4;
    localparam int POS_W     = 3;
    localparam int IN_VAL_W  = 32;
    localparam int OUT_VAL_W = 32;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;
    localparam int M_PAD_W   = M_TDATA_W - 2 * POS_W - OUT_VAL_W;

    // controller states
    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } t_state;

    // per-cycle command to every cell of the chain
    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctrl;

    // command to the zigzag position generator
    typedef struct packed {
        logic restart;
        logic step;
    } t_scan_ctrl;

    // dimension register write: zero becomes one, too large becomes the maximum
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] max_dim);
        logic [DIM_W-1:0] d;
        d = v;
        if (d == '0) begin
            d = DIM_W'(1);
        end
        if (d > max_dim) begin
            d = max_dim;
        end
        return d;
    endfunction

endpackage

[rtl/szz_cell.sv]
// ---------------------------------------------------------------------------
// szz_cell
// one slot of the sorting chain: insert by compare, shift out toward slot 0
// ---------------------------------------------------------------------------
module szz_cell
    import szz_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int CNT_W      = 7,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  t_cell_ctrl            i_ctrl,
    input  logic [CNT_W-1:0]      i_count,
    input  logic [VALUE_BITS-1:0] i_new,
    input  logic [VALUE_BITS-1:0] i_left_value,
    input  logic                  i_left_gt,
    input  logic [VALUE_BITS-1:0] i_right_value,
    output logic [VALUE_BITS-1:0] o_value,
    output logic                  o_gt
);

    logic [VALUE_BITS-1:0] r_value;
    logic [VALUE_BITS-1:0] n_value;
    logic                  w_occupied;
    logic                  w_first_free;

    // slots below the fill count hold sorted data
    assign w_occupied   = (i_count > CNT_W'(INDEX));
    assign w_first_free = (i_count == CNT_W'(INDEX));
    assign o_gt         = w_occupied && ($signed(r_value) > $signed(i_new));

    // larger values move up one slot, the new one lands at the boundary
    always_comb begin
        n_value = r_value;
        if (i_ctrl.insert) begin
            if (o_gt || w_first_free) begin
                n_value = i_left_gt ? i_left_value : i_new;
            end
        end else if (i_ctrl.shift) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

[rtl/szz_scan.sv]
// ---------------------------------------------------------------------------
// szz_scan
// zigzag position generator bouncing off the edges of a rows x cols matrix
// ---------------------------------------------------------------------------
module szz_scan
    import szz_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_scan_ctrl       i_ctrl,
    input  logic [DIM_W-1:0] i_rows,
    input  logic [DIM_W-1:0] i_cols,
    output logic [POS_W-1:0] o_row,
    output logic [POS_W-1:0] o_col
);

    logic [POS_W-1:0] r_row;
    logic [POS_W-1:0] r_col;
    logic             r_up;
    logic [POS_W-1:0] n_row;
    logic [POS_W-1:0] n_col;
    logic             n_up;
    logic [DIM_W-1:0] w_row_p1;
    logic [DIM_W-1:0] w_col_p1;

    assign w_row_p1 = DIM_W'(r_row) + DIM_W'(1);
    assign w_col_p1 = DIM_W'(r_col) + DIM_W'(1);

    // next position along the diagonal scan
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        n_up  = r_up;
        if (i_ctrl.restart) begin
            n_row = '0;
            n_col = '0;
            n_up  = 1'b1;
        end else if (i_ctrl.step) begin
            if (r_up) begin
                if (w_col_p1 >= i_cols) begin
                    n_row = r_row + POS_W'(1);
                    n_up  = 1'b0;
                end else if (r_row == '0) begin
                    n_col = r_col + POS_W'(1);
                    n_up  = 1'b0;
                end else begin
                    n_row = r_row - POS_W'(1);
                    n_col = r_col + POS_W'(1);
                end
            end else begin
                if (w_row_p1 >= i_rows) begin
                    n_col = r_col + POS_W'(1);
                    n_up  = 1'b1;
                end else if (r_col == '0) begin
                    n_row = r_row + POS_W'(1);
                    n_up  = 1'b1;
                end else begin
                    n_row = r_row + POS_W'(1);
                    n_col = r_col - POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_up  <= 1'b1;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
            r_up  <= n_up;
        end
    end

    assign o_row = r_row;
    assign o_col = r_col;

endmodule

[rtl/sorted_zigzag_matrix_fill.sv]
// Handoff: the first result is offered in the cycle after the last value of a matrix is taken.
// Throughput: one value per cycle while loading, one result per cycle while draining and
// the output is ready; the chain is either loading or draining.
// Loading and draining are both bounded by the single shared row of sorting cells.
// Reset: rows and cols go to 8 (clamped to MAX_DIM), fill count to zero, scan to (0,0).
// ---------------------------------------------------------------------------
// sorted_zigzag_matrix_fill
// sorts a loaded matrix in an insertion chain and emits it in zigzag order
// ---------------------------------------------------------------------------
module sorted_zigzag_matrix_fill
    import szz_pkg::*;
#(
    parameter int MAX_DIM    = 8,
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // stream in
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,   // [31:0] value
    // stream out
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata,   // [2:0] out_row, [5:3] out_col,
                                                    // [37:6] out_value, [39:38] zero
    output logic                  o_m_axis_tlast,   // last_of_run
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CAP   = MAX_DIM * MAX_DIM;
    localparam int CNT_W = $clog2(CAP + 1);

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [DIM_W-1:0] r_rows;
    logic [DIM_W-1:0] r_cols;

    logic [2*DIM_W-1:0]    w_prod;
    logic [CNT_W-1:0]      w_total;
    logic                  w_in_acc;
    logic                  w_out_acc;
    logic [VALUE_BITS-1:0] w_new;
    t_cell_ctrl            w_cell_ctrl;
    t_scan_ctrl            w_scan_ctrl;
    logic [POS_W-1:0]      w_row;
    logic [POS_W-1:0]      w_col;
    logic [VALUE_BITS-1:0] w_val [CAP];
    logic                  w_gt  [CAP];

    // matrix size, bounded by the clamped registers
    assign w_prod  = (2 * DIM_W)'(r_rows) * (2 * DIM_W)'(r_cols);
    assign w_total = CNT_W'(w_prod);
    assign w_new   = VALUE_BITS'(i_s_axis_tdata);

    assign o_s_axis_tready = (r_state == ST_LOAD);
    assign o_m_axis_tvalid = (r_state == ST_DRAIN);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc       = o_m_axis_tvalid && i_m_axis_tready;

    // load / drain sequencing
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        w_cell_ctrl = '0;
        w_scan_ctrl = '0;
        if (i_cfg_we) begin
            n_state             = ST_LOAD;
            n_count             = '0;
            w_scan_ctrl.restart = 1'b1;
        end else begin
            unique case (r_state)
                ST_LOAD: begin
                    if (w_in_acc) begin
                        w_cell_ctrl.insert = 1'b1;
                        n_count            = r_count + CNT_W'(1);
                        if (n_count == w_total) begin
                            n_state = ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN: begin
                    if (w_out_acc) begin
                        w_cell_ctrl.shift = 1'b1;
                        w_scan_ctrl.step  = 1'b1;
                        n_count           = r_count - CNT_W'(1);
                        if (r_count == CNT_W'(1)) begin
                            n_state             = ST_LOAD;
                            w_scan_ctrl.restart = 1'b1;
                        end
                    end
                end
                default: begin
                    n_state = ST_LOAD;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // dimension registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= clamp_dim(DIM_W'(8), DIM_W'(MAX_DIM));
            r_cols <= clamp_dim(DIM_W'(8), DIM_W'(MAX_DIM));
        end else if (i_cfg_we) begin
            if (i_cfg_addr == CFG_ROWS) begin
                r_rows <= clamp_dim(i_cfg_data, DIM_W'(MAX_DIM));
            end else if (i_cfg_addr == CFG_COLS) begin
                r_cols <= clamp_dim(i_cfg_data, DIM_W'(MAX_DIM));
            end
        end
    end

    // sorting chain, slot 0 holds the smallest value
    for (genvar g = 0; g < CAP; g++) begin : g_cell
        logic [VALUE_BITS-1:0] w_left;
        logic                  w_left_gt;
        logic [VALUE_BITS-1:0] w_right;

        if (g == 0) begin : g_head
            assign w_left    = w_new;
            assign w_left_gt = 1'b0;
        end else begin : g_body
            assign w_left    = w_val[g-1];
            assign w_left_gt = w_gt[g-1];
        end

        if (g == CAP - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_val[g+1];
        end

        szz_cell #(
            .VALUE_BITS (VALUE_BITS),
            .CNT_W      (CNT_W),
            .INDEX      (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_cell_ctrl),
            .i_count       (r_count),
            .i_new         (w_new),
            .i_left_value  (w_left),
            .i_left_gt     (w_left_gt),
            .i_right_value (w_right),
            .o_value       (w_val[g]),
            .o_gt          (w_gt[g])
        );
    end

    // zigzag placement
    szz_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_scan_ctrl),
        .i_rows  (r_rows),
        .i_cols  (r_cols),
        .o_row   (w_row),
        .o_col   (w_col)
    );

    // result item straight from slot 0 and the scan registers
    assign o_m_axis_tdata = {M_PAD_W'(0), OUT_VAL_W'(w_val[0]), w_col, w_row};
    assign o_m_axis_tlast = (r_count == CNT_W'(1));

endmodule

[rtl/szz_checker.sv]
// ---------------------------------------------------------------------------
// szz_checker
// port-level checks on the sorted zigzag matrix fill block
// ---------------------------------------------------------------------------
`include "sorted_zigzag_matrix_fill_assert.svh"

module szz_checker
    import szz_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_s_axis_tready,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [M_TDATA_W-1:0] o_m_axis_tdata,
    input logic                 o_m_axis_tlast,
    input logic                 i_cfg_we
);

    // loading and draining never overlap
    `SZZ_ASSERT(a_no_overlap, !(o_s_axis_tready && o_m_axis_tvalid), "load and drain overlap")

    // a stalled result item holds still
    `SZZ_ASSERT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready && !i_cfg_we |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast), "stalled item changed")

    // after the final placement the block is ready for a new matrix
    `SZZ_ASSERT(a_reload, o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast |=> o_s_axis_tready, "not ready after last item")

    // every drain starts at the top left corner
    `SZZ_ASSERT(a_origin, $rose(o_m_axis_tvalid) |-> o_m_axis_tdata[2*POS_W-1:0] == '0, "drain not starting at origin")

endmodule

bind sorted_zigzag_matrix_fill szz_checker u_szz_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .i_cfg_we        (i_cfg_we)
);

[dv/szz_fill_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// szz_fill_checker
// watches the value stream, the configuration writes and the placement
// stream; keeps its own sorted copy of each matrix, builds the zigzag
// placements when a matrix completes and compares every placement item
// ---------------------------------------------------------------------------
module szz_fill_checker
    import szz_pkg::*;
#(
    parameter int MAX_DIM = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [M_TDATA_W-1:0]  i_m_tdata,
    input  logic                  i_m_tlast,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_pending,
    output int                    o_fail_count
);

    localparam int MAX_CELLS = MAX_DIM * MAX_DIM;

    typedef struct packed {
        logic [POS_W-1:0]            pos_row;
        logic [POS_W-1:0]            pos_col;
        logic signed [OUT_VAL_W-1:0] value;
        logic                        last_flag;
    } t_placement;

    t_placement                 placements_q[$];
    logic signed [IN_VAL_W-1:0] sorted_vals[MAX_CELLS];
    int                         fill_count;
    int                         dim_rows;
    int                         dim_cols;
    int                         fail_total;

    initial begin
        fill_count = 0;
        dim_rows   = MAX_DIM;
        dim_cols   = MAX_DIM;
        fail_total = 0;
    end

    // register write value: zero means one, anything above the maximum means the maximum
    function automatic int fit_dim(input logic [CFG_DATA_W-1:0] raw);
        int d;
        d = int'(raw);
        if (d < 1) begin
            d = 1;
        end
        if (d > MAX_DIM) begin
            d = MAX_DIM;
        end
        return d;
    endfunction

    task automatic flag_error(input string what, input logic [63:0] want,
                              input logic [63:0] got);
        fail_total++;
        $display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h",
                 $time, what, want, got);
    endtask

    // insert one value in ascending order; a full matrix yields its zigzag placements
    task automatic take_value(input logic signed [IN_VAL_W-1:0] v);
        int         cells;
        int         slot;
        int         r;
        int         c;
        bit         going_up;
        t_placement p;
        cells = dim_rows * dim_cols;
        if (fill_count >= cells) begin
            fill_count = 0;
        end
        slot = fill_count;
        while (slot > 0 && sorted_vals[slot-1] > v) begin
            sorted_vals[slot] = sorted_vals[slot-1];
            slot--;
        end
        sorted_vals[slot] = v;
        fill_count++;
        if (fill_count < cells) begin
            return;
        end
        r        = 0;
        c        = 0;
        going_up = 1'b1;
        for (int k = 0; k < cells; k++) begin
            p.pos_row   = POS_W'(r);
            p.pos_col   = POS_W'(c);
            p.value     = sorted_vals[k];
            p.last_flag = (k == cells - 1);
            placements_q.push_back(p);
            // diagonal walk, bouncing off the edges, right and bottom ahead of top and left
            if (going_up) begin
                if (c + 1 >= dim_cols) begin
                    r++;
                    going_up = 1'b0;
                end else if (r == 0) begin
                    c++;
                    going_up = 1'b0;
                end else begin
                    r--;
                    c++;
                end
            end else begin
                if (r + 1 >= dim_rows) begin
                    c++;
                    going_up = 1'b1;
                end else if (c == 0) begin
                    r++;
                    going_up = 1'b1;
                end else begin
                    r++;
                    c--;
                end
            end
        end
        fill_count = 0;
    endtask

    // compare one accepted placement item with the oldest expectation
    task automatic check_placement();
        t_placement want;
        if (placements_q.size() == 0) begin
            flag_error("unexpected placement item", '0, 64'(i_m_tdata));
            return;
        end
        want = placements_q.pop_front();
        if (i_m_tdata[POS_W-1:0] !== want.pos_row) begin
            flag_error("out_row", 64'(want.pos_row), 64'(i_m_tdata[POS_W-1:0]));
        end
        if (i_m_tdata[2*POS_W-1:POS_W] !== want.pos_col) begin
            flag_error("out_col", 64'(want.pos_col), 64'(i_m_tdata[2*POS_W-1:POS_W]));
        end
        if (i_m_tdata[2*POS_W+OUT_VAL_W-1:2*POS_W] !== want.value) begin
            flag_error("out_value", 64'(want.value),
                       64'(i_m_tdata[2*POS_W+OUT_VAL_W-1:2*POS_W]));
        end
        if (i_m_tdata[M_TDATA_W-1:2*POS_W+OUT_VAL_W] !== '0) begin
            flag_error("tdata padding", '0, 64'(i_m_tdata[M_TDATA_W-1:2*POS_W+OUT_VAL_W]));
        end
        if (i_m_tlast !== want.last_flag) begin
            flag_error("last_of_run", 64'(want.last_flag), 64'(i_m_tlast));
        end
    endtask

    // monitor all channels at each rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            placements_q.delete();
            fill_count = 0;
            dim_rows   = MAX_DIM;
            dim_cols   = MAX_DIM;
        end else begin
            // any register write drops a partly loaded matrix
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_ROWS) begin
                    dim_rows   = fit_dim(i_cfg_data);
                    fill_count = 0;
                end else if (i_cfg_addr == CFG_COLS) begin
                    dim_cols   = fit_dim(i_cfg_data);
                    fill_count = 0;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                take_value($signed(i_s_tdata[IN_VAL_W-1:0]));
            end
            if (i_m_tvalid && i_m_tready) begin
                check_placement();
            end
        end
        o_pending    <= placements_q.size();
        o_fail_count <= fail_total;
    end

endmodule

[dv/sorted_zigzag_matrix_fill_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sorted_zigzag_matrix_fill_tb
// drives matrices of signed values under many row and column settings,
// with random gaps on both streams, a long output stall and a full drain
// pause; the checker beside the block predicts and compares each item
// ---------------------------------------------------------------------------
module sorted_zigzag_matrix_fill_tb;
    import szz_pkg::*;

    localparam int MAX_DIM     = 8;
    localparam int ITEM_TARGET = 450;
    localparam int QUIET_TAIL  = 60;
    localparam int LONG_HOLD   = 200;
    localparam int SETTLE      = 8;
    localparam int STALL_LIMIT = 4000;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_valid  = 1'b0;
    logic [S_TDATA_W-1:0]  s_data   = '0;
    logic                  s_ready;
    logic                  m_valid;
    logic                  m_ready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_data;
    logic                  m_last;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = CFG_ROWS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int pending;
    int fail_count;
    int items_sent   = 0;
    int stall_cycles = 0;
    int rx_hold_req  = 0;
    bit rx_idle_en   = 1'b0;
    bit tx_idle_en   = 1'b0;
    int mat_rows     = MAX_DIM;
    int mat_cols     = MAX_DIM;

    // 4 ns clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    sorted_zigzag_matrix_fill #(
        .MAX_DIM    (MAX_DIM),
        .VALUE_BITS (32)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_data      (cfg_data)
    );

    szz_fill_checker #(
        .MAX_DIM (MAX_DIM)
    ) checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_valid),
        .i_s_tready   (s_ready),
        .i_s_tdata    (s_data),
        .i_m_tvalid   (m_valid),
        .i_m_tready   (m_ready),
        .i_m_tdata    (m_data),
        .i_m_tlast    (m_last),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // output ready: random bursts low, plus the requested long hold
    initial begin : rx_ready_gen
        int seen;
        seen = 0;
        forever begin
            @(posedge clk);
            if (rx_hold_req != seen) begin
                seen = rx_hold_req;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                m_ready <= 1'b1;
            end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no item moving on either stream
    always @(posedge clk) begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // offer one value, with an optional random gap first
    task automatic send_item(input logic [IN_VAL_W-1:0] v);
        if (tx_idle_en && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= v;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        items_sent++;
    endtask

    // extremes, small clustered values for ties, and full random words
    function automatic logic [IN_VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            1, 2:    return 32'(int'($urandom_range(0, 6)) - 3);
            default: return $urandom();
        endcase
    endfunction

    task automatic send_values(input int count);
        for (int i = 0; i < count; i++) begin
            send_item(pick_value());
        end
    endtask

    // stop offering and wait for every expected placement
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // idle point for register writes
    task automatic quiesce();
        wait_drained();
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] raw);
        int eff;
        eff = (raw == 0) ? 1 : ((int'(raw) > MAX_DIM) ? MAX_DIM : int'(raw));
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= raw;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_ROWS) begin
            mat_rows = eff;
        end else begin
            mat_cols = eff;
        end
    endtask

    // mostly small dimensions, sometimes zero, the maximum or above it
    function automatic logic [CFG_DATA_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return CFG_DATA_W'($urandom_range(MAX_DIM + 1, 15));
            2:       return CFG_DATA_W'(MAX_DIM);
            default: return CFG_DATA_W'($urandom_range(1, 4));
        endcase
    endfunction

    initial begin
        int n_mats;
        int cells;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: 1x1 matrices with the value extremes
        quiesce();
        cfg_write(CFG_ROWS, 4'd0);
        cfg_write(CFG_COLS, 4'd0);
        send_item(32'h8000_0000);
        send_item(32'h7FFF_FFFF);
        send_item(32'h0000_0000);

        // directed: oversized rows give one 8x1 column with ties and extremes
        quiesce();
        cfg_write(CFG_ROWS, 4'd15);
        cfg_write(CFG_COLS, 4'd1);
        send_item(32'h7FFF_FFFF);
        send_item(32'h8000_0000);
        send_item(32'h0000_0000);
        send_item(32'hFFFF_FFFF);
        send_item(32'd5);
        send_item(32'd5);
        send_item(32'h8000_0001);
        send_item(32'h7FFF_FFFE);

        // directed: 1x8 row loaded in descending order
        quiesce();
        cfg_write(CFG_ROWS, 4'd1);
        cfg_write(CFG_COLS, 4'd9);
        for (int k = 0; k < MAX_DIM; k++) begin
            send_item(32'(7 - 2 * k));
        end

        // directed: a register write in the middle of a 2x2 load drops it
        quiesce();
        cfg_write(CFG_ROWS, 4'd2);
        cfg_write(CFG_COLS, 4'd2);
        send_item(32'd100);
        send_item(32'hFFFF_FF00);
        send_item(32'd3);
        quiesce();
        cfg_write(CFG_COLS, 4'd2);
        send_item(32'd9);
        send_item(32'hFFFF_FFFF);
        send_item(32'd9);
        send_item(32'h8000_0000);

        // long output hold while two 4x4 matrices are offered, then a full drain
        quiesce();
        cfg_write(CFG_ROWS, 4'd4);
        cfg_write(CFG_COLS, 4'd4);
        rx_hold_req <= rx_hold_req + 1;
        send_values(16);
        send_values(16);
        wait_drained();

        // random phases
        while (items_sent < ITEM_TARGET) begin
            quiesce();
            if ($urandom_range(0, 3) != 0) begin
                cfg_write(CFG_ROWS, pick_dim());
                cfg_write(CFG_COLS, pick_dim());
            end else if ($urandom_range(0, 1) == 0) begin
                cfg_write(CFG_ROWS, pick_dim());
            end else begin
                cfg_write(CFG_COLS, pick_dim());
            end
            if (items_sent >= ITEM_TARGET - QUIET_TAIL) begin
                tx_idle_en = 1'b0;
                rx_idle_en <= 1'b0;
            end else begin
                tx_idle_en = ($urandom_range(0, 3) != 0);
                rx_idle_en <= ($urandom_range(0, 3) != 0);
            end
            cells  = mat_rows * mat_cols;
            n_mats = $urandom_range(1, 3);
            for (int m = 0; m < n_mats && items_sent < ITEM_TARGET; m++) begin
                send_values(cells);
                if ($urandom_range(0, 3) == 0) begin
                    wait_drained();
                end
            end
            // sometimes leave a partial matrix for the next write to drop
            if (cells > 1 && items_sent < ITEM_TARGET && $urandom_range(0, 5) == 0) begin
                send_values($urandom_range(1, cells - 1));
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
